// ===== design/contact_element_quadrature_defines.svh =====
// Assertion macros used by the contact element quadrature engine.
`ifndef CONTACT_ELEMENT_QUADRATURE_DEFINES_SVH
`define CONTACT_ELEMENT_QUADRATURE_DEFINES_SVH

`ifndef ASSERT_OFF
`define CEQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ceq check failed");
`define CEQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ceq check failed");
`else
`define CEQ_ASSERT(label, clk, rst, prop)
`define CEQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/ceq_pkg.sv =====
package ceq_pkg;

  localparam int MAX_QUAD_DEF       = 8;
  localparam int MAX_SIDE_NODES_DEF = 8;
  localparam int MAX_EQU_DEF        = 4;
  localparam int MAX_COMP_DEF       = 4;

  localparam int VAL_W    = 32;
  localparam int MAG_W    = 128;
  localparam int TERM_W   = 129;
  localparam int ACC_W    = 132;
  localparam int RND_POS  = 47;
  localparam int FRAC_SH  = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

  localparam logic [2:0] FUNC_SHAPE  = 3'd0;
  localparam logic [2:0] FUNC_WEIGHT = 3'd1;
  localparam logic [2:0] FUNC_D      = 3'd2;
  localparam logic [2:0] FUNC_Y      = 3'd3;
  localparam logic [2:0] FUNC_MAT    = 3'd4;
  localparam logic [2:0] FUNC_RHS    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_QUAD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EQU   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DPP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YPP   = 3'd5;

  function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== design/ceq_ifs.sv =====
interface ceq_req_if import ceq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic [2:0]        row_index;
  logic [2:0]        col_node;
  logic [2:0]        quad_index;
  logic [1:0]        equ_index;
  logic [1:0]        comp_index;
  logic signed [VAL_W-1:0] load_value;
  modport source (output valid, func, row_index, col_node, quad_index, equ_index,
                  comp_index, load_value, input ready);
  modport sink (input valid, func, row_index, col_node, quad_index, equ_index,
                comp_index, load_value, output ready);
endinterface

interface ceq_rsp_if import ceq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic signed [VAL_W-1:0] sum_value;
  logic              saturated;
  modport source (output valid, sum_value, saturated, input ready);
  modport sink (input valid, sum_value, saturated, output ready);
endinterface

interface ceq_cfg_if import ceq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/ceq_term.sv =====
module ceq_term import ceq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [VAL_W-1:0]         a,
  input  logic [VAL_W-1:0]         b,
  input  logic [VAL_W-1:0]         c,
  input  logic [VAL_W-1:0]         d,
  output logic                     done,
  output logic signed [TERM_W-1:0] term
);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_MUL   = 5'b00010,
    T_DRAIN = 5'b00100,
    T_SIGN  = 5'b01000,
    T_DONE  = 5'b10000
  } tstate_t;

  tstate_t state;
  logic [MAG_W-1:0] src;
  logic [MAG_W-1:0] part;
  logic [MAG_W-1:0] mag;
  logic [VAL_W-1:0] fac [3];
  logic [63:0]      prod;
  logic             prod_v;
  logic [1:0]       prod_sh;
  logic [1:0]       i;
  logic [1:0]       j;
  logic             neg;
  logic [MAG_W-1:0] prod_shifted;
  logic [MAG_W-1:0] sum;

  assign prod_shifted = MAG_W'(prod) << {prod_sh, 5'b0};
  assign sum          = part + prod_shifted;
  assign done         = (state == T_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_IDLE;
      prod_v <= 1'b0;
    end else begin
      case (state)
        T_IDLE: begin
          if (start) begin
            src    <= MAG_W'(mag32(a));
            fac[0] <= mag32(b);
            fac[1] <= mag32(c);
            fac[2] <= mag32(d);
            neg    <= a[VAL_W-1] ^ b[VAL_W-1] ^ c[VAL_W-1] ^ d[VAL_W-1];
            part   <= '0;
            prod_v <= 1'b0;
            i      <= 2'd0;
            j      <= 2'd0;
            state  <= T_MUL;
          end
        end
        T_MUL: begin
          prod    <= 64'(src[32*i +: 32]) * 64'(fac[j]);
          prod_sh <= i;
          prod_v  <= 1'b1;
          if (prod_v) begin
            part <= sum;
          end
          if (i == j) begin
            state <= T_DRAIN;
          end else begin
            i <= i + 2'd1;
          end
        end
        T_DRAIN: begin
          prod_v <= 1'b0;
          if (j == 2'd2) begin
            mag   <= sum;
            state <= T_SIGN;
          end else begin
            src   <= sum;
            part  <= '0;
            j     <= j + 2'd1;
            i     <= 2'd0;
            state <= T_MUL;
          end
        end
        T_SIGN: begin
          term  <= neg ? (TERM_W'(0) - {1'b0, mag}) : {1'b0, mag};
          state <= T_DONE;
        end
        T_DONE: begin
          state <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/contact_element_quadrature.sv =====
// Contact element quadrature engine.
// Channels: req (sink) takes load and query requests, rsp (source) returns
// one sum per matrix or right-hand-side query, cfg (sink) writes the six
// configuration registers and is always ready.
// A load request writes one entry of the shape, weight, D or Y store when its
// indices are in range. A query walks its n quadrature points one at a time:
// a store read step and an operand setup step, then the term unit, whose
// single 32x32 multiplier forms the four-factor product limb by limb.
// A query out of range, or with n of zero, accumulates no points and
// returns a zero sum.
// req is ready only between queries; loads may follow one per cycle.
// The result waits in an output register: the next request is taken while
// it waits, and a following query holds at its last step until rsp drains.
// Reset clears the control state and sets the registers to 1,1,1,1,0,0;
// the stores are not cleared and hold no valid data until written.
module contact_element_quadrature import ceq_pkg::*; #(
  parameter int MAX_QUAD       = MAX_QUAD_DEF,
  parameter int MAX_SIDE_NODES = MAX_SIDE_NODES_DEF,
  parameter int MAX_EQU        = MAX_EQU_DEF,
  parameter int MAX_COMP       = MAX_COMP_DEF
) (
  input logic clk,
  input logic rst,
  ceq_req_if.sink   req,
  ceq_rsp_if.source rsp,
  ceq_cfg_if.sink   cfg
);

`include "contact_element_quadrature_defines.svh"

  localparam int SH_DEPTH = MAX_SIDE_NODES * MAX_QUAD;
  localparam int D_DEPTH  = MAX_QUAD * MAX_EQU * MAX_COMP;
  localparam int Y_DEPTH  = MAX_QUAD * MAX_EQU;
  localparam int SAW = (SH_DEPTH > 1) ? $clog2(SH_DEPTH) : 1;
  localparam int WAW = (MAX_QUAD > 1) ? $clog2(MAX_QUAD) : 1;
  localparam int DAW = (D_DEPTH > 1) ? $clog2(D_DEPTH) : 1;
  localparam int YAW = (Y_DEPTH > 1) ? $clog2(Y_DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_OP   = 5'b00100,
    S_WAIT = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;

  logic [3:0] quad_points;
  logic [3:0] side_nodes;
  logic [2:0] equations;
  logic [2:0] components;
  logic       d_per_point;
  logic       y_per_point;

  logic [VAL_W-1:0] shape_mem  [SH_DEPTH];
  logic [VAL_W-1:0] weight_mem [MAX_QUAD];
  logic [VAL_W-1:0] d_mem      [D_DEPTH];
  logic [VAL_W-1:0] y_mem      [Y_DEPTH];

  logic [VAL_W-1:0] sh_s_rd, sh_r_rd, w_rd, d_rd, y_rd;

  logic       is_mat;
  logic [2:0] qs, qr;
  logic [1:0] qk, qm;
  logic [3:0] q;
  logic [3:0] n_pts;
  logic [ACC_W-1:0] acc;

  logic             out_valid;
  logic [VAL_W-1:0] out_sum;
  logic             out_sat;

  logic accept;
  logic is_query;
  logic q_valid;
  logic [3:0] n_next;
  logic [31:0] ld_sh, ld_d, ld_y;
  logic [31:0] rd_sh_s, rd_sh_r, rd_d, rd_y;
  logic [3:0]  dq, yq;
  logic ld_sh_ok, ld_w_ok, ld_d_ok, ld_y_ok;

  logic       term_start;
  logic       term_done;
  logic signed [TERM_W-1:0] term;
  logic [VAL_W-1:0] op_c, op_d;

  logic [ACC_W-1:0] rnd;
  logic             fits;
  logic             slot_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_query  = (req.func == FUNC_MAT) || (req.func == FUNC_RHS);
  assign cfg.ready = 1'b1;

  assign rsp.valid     = out_valid;
  assign rsp.sum_value = out_sum;
  assign rsp.saturated = out_sat;

  always_comb begin
    q_valid = (32'(req.row_index) < 32'(side_nodes)) &&
              (32'(req.row_index) < 32'(MAX_SIDE_NODES)) &&
              (32'(req.equ_index) < 32'(equations)) &&
              (32'(req.equ_index) < 32'(MAX_EQU));
    if (req.func == FUNC_MAT) begin
      q_valid = q_valid &&
                (32'(req.col_node) < 32'(side_nodes)) &&
                (32'(req.col_node) < 32'(MAX_SIDE_NODES)) &&
                (32'(req.comp_index) < 32'(components)) &&
                (32'(req.comp_index) < 32'(MAX_COMP));
    end
    n_next = (32'(quad_points) > 32'(MAX_QUAD)) ? 4'(MAX_QUAD) : quad_points;
  end

  assign ld_sh_ok = (32'(req.row_index) < 32'(MAX_SIDE_NODES)) &&
                    (32'(req.quad_index) < 32'(MAX_QUAD));
  assign ld_w_ok  = (32'(req.quad_index) < 32'(MAX_QUAD));
  assign ld_d_ok  = ld_w_ok && (32'(req.equ_index) < 32'(MAX_EQU)) &&
                    (32'(req.comp_index) < 32'(MAX_COMP));
  assign ld_y_ok  = ld_w_ok && (32'(req.equ_index) < 32'(MAX_EQU));

  assign ld_sh = 32'(req.row_index) * 32'(MAX_QUAD) + 32'(req.quad_index);
  assign ld_d  = (32'(req.quad_index) * 32'(MAX_EQU) + 32'(req.equ_index)) *
                 32'(MAX_COMP) + 32'(req.comp_index);
  assign ld_y  = 32'(req.quad_index) * 32'(MAX_EQU) + 32'(req.equ_index);

  assign dq      = d_per_point ? q : 4'd0;
  assign yq      = y_per_point ? q : 4'd0;
  assign rd_sh_s = 32'(qs) * 32'(MAX_QUAD) + 32'(q);
  assign rd_sh_r = 32'(qr) * 32'(MAX_QUAD) + 32'(q);
  assign rd_d    = (32'(dq) * 32'(MAX_EQU) + 32'(qk)) * 32'(MAX_COMP) + 32'(qm);
  assign rd_y    = 32'(yq) * 32'(MAX_EQU) + 32'(qk);

  always_ff @(posedge clk) begin
    if (accept && (req.func == FUNC_SHAPE) && ld_sh_ok) begin
      shape_mem[ld_sh[SAW-1:0]] <= req.load_value;
    end
    if (accept && (req.func == FUNC_WEIGHT) && ld_w_ok) begin
      weight_mem[req.quad_index[WAW-1:0]] <= req.load_value;
    end
    if (accept && (req.func == FUNC_D) && ld_d_ok) begin
      d_mem[ld_d[DAW-1:0]] <= req.load_value;
    end
    if (accept && (req.func == FUNC_Y) && ld_y_ok) begin
      y_mem[ld_y[YAW-1:0]] <= req.load_value;
    end
    sh_s_rd <= shape_mem[rd_sh_s[SAW-1:0]];
    sh_r_rd <= shape_mem[rd_sh_r[SAW-1:0]];
    w_rd    <= weight_mem[WAW'(q)];
    d_rd    <= d_mem[rd_d[DAW-1:0]];
    y_rd    <= y_mem[rd_y[YAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_points <= 4'd1;
      side_nodes  <= 4'd1;
      equations   <= 3'd1;
      components  <= 3'd1;
      d_per_point <= 1'b0;
      y_per_point <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_QUAD: quad_points <= cfg.data[3:0];
        REG_SIDE: side_nodes  <= cfg.data[3:0];
        REG_EQU:  equations   <= cfg.data[2:0];
        REG_COMP: components  <= cfg.data[2:0];
        REG_DPP:  d_per_point <= cfg.data[0];
        REG_YPP:  y_per_point <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  assign op_c       = is_mat ? d_rd : y_rd;
  assign op_d       = is_mat ? sh_r_rd : ONE_Q16;
  assign term_start = (state == S_OP);

  ceq_term u_term (
    .clk   (clk),
    .rst   (rst),
    .start (term_start),
    .a     (w_rd),
    .b     (sh_s_rd),
    .c     (op_c),
    .d     (op_d),
    .done  (term_done),
    .term  (term)
  );

  assign rnd       = acc + (ACC_W'(1) << RND_POS);
  assign fits      = (rnd[ACC_W-1:FRAC_SH+VAL_W-1] ==
                      {(ACC_W-FRAC_SH-VAL_W+1){rnd[ACC_W-1]}});
  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !((state == S_FIN) && slot_free)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && is_query) begin
            is_mat <= (req.func == FUNC_MAT);
            qs     <= req.row_index;
            qr     <= req.col_node;
            qk     <= req.equ_index;
            qm     <= req.comp_index;
            q      <= 4'd0;
            n_pts  <= n_next;
            acc    <= '0;
            state  <= (q_valid && (n_next != 4'd0)) ? S_RD : S_FIN;
          end
        end
        S_RD: begin
          state <= S_OP;
        end
        S_OP: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (term_done) begin
            acc <= acc + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
            if (q == n_pts - 4'd1) begin
              state <= S_FIN;
            end else begin
              q     <= q + 4'd1;
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_sum   <= fits ? rnd[FRAC_SH+VAL_W-1:FRAC_SH]
                              : (rnd[ACC_W-1] ? SAT_NEG : SAT_POS);
            out_sat   <= !fits;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CEQ_ASSERT(a_done_in_wait, clk, rst, term_done |-> (state == S_WAIT))
  `CEQ_ASSERT(a_fin_holds, clk, rst,
    ((state == S_FIN) && out_valid && !rsp.ready) |=> (state == S_FIN))
  `CEQ_ASSERT(a_point_in_range, clk, rst, (state == S_RD) |-> (q < n_pts))

endmodule

// ===== dv/tb_contact_element_quadrature.sv =====
`timescale 1ns / 100ps

module tb_contact_element_quadrature;
  import ceq_pkg::*;

  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;
  localparam int NQ = MAX_QUAD_DEF;
  localparam int NS = MAX_SIDE_NODES_DEF;
  localparam int NE = MAX_EQU_DEF;
  localparam int NC = MAX_COMP_DEF;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 150;

  typedef struct packed {
    logic [2:0]        func;
    logic [2:0]        row_index;
    logic [2:0]        col_node;
    logic [2:0]        quad_index;
    logic [1:0]        equ_index;
    logic [1:0]        comp_index;
    logic [VAL_W-1:0]  load_value;
  } request_t;

  typedef struct packed {
    logic [VAL_W-1:0] sum_value;
    logic             saturated;
  } sum_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    sum_t     sum;
  } row_t;

  logic clk;
  logic rst;

  ceq_req_if req_if ();
  ceq_rsp_if rsp_if ();
  ceq_cfg_if cfg_if ();

  contact_element_quadrature DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source),
    .cfg (cfg_if.sink)
  );

  logic signed [VAL_W-1:0] shape_mem [NS*NQ];
  logic signed [VAL_W-1:0] weight_mem [NQ];
  logic signed [VAL_W-1:0] d_mem [NQ*NE*NC];
  logic signed [VAL_W-1:0] y_mem [NQ*NE];
  logic [3:0] n_quad, n_side;
  logic [2:0] n_equ, n_comp;
  logic       d_varies, y_varies;

  sum_t pending_sums [$];
  int   errors;
  int   n_loads, n_queries, n_sums, n_clipped;
  bit   hold_rsp;
  bit   send_eager;
  bit   rsp_eager;
  int   idle_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic sum_t quadrature_sum(input request_t r);
    sum_t                  res;
    logic signed [159:0]   acc;
    logic signed [159:0]   term;
    logic signed [159:0]   sh;
    int                    n;
    int                    s;
    int                    c;
    int                    k;
    int                    m;
    int                    dq;
    int                    yq;
    res = '0;
    s = int'(r.row_index);
    c = int'(r.col_node);
    k = int'(r.equ_index);
    m = int'(r.comp_index);
    if (s >= int'(n_side) || k >= int'(n_equ)) return res;
    if (r.func == FUNC_MAT && (c >= int'(n_side) || m >= int'(n_comp))) return res;
    n = (int'(n_quad) > NQ) ? NQ : int'(n_quad);
    acc = '0;
    for (int q = 0; q < n; q++) begin
      term = 160'(weight_mem[q]);
      term = term * shape_mem[s*NQ + q];
      if (r.func == FUNC_MAT) begin
        dq = d_varies ? q : 0;
        term = term * d_mem[(dq*NE + k)*NC + m];
        term = term * shape_mem[c*NQ + q];
      end else begin
        yq = y_varies ? q : 0;
        term = term * y_mem[yq*NE + k];
        term = term * $signed({1'b0, ONE_Q16});
      end
      acc = acc + term;
    end
    acc = acc + (160'sd1 <<< RND_POS);
    sh = acc >>> FRAC_SH;
    if (&sh[159:31] || ~|sh[159:31]) begin
      res.sum_value = sh[31:0];
    end else begin
      res.sum_value = sh[159] ? SAT_NEG : SAT_POS;
      res.saturated = 1'b1;
    end
    return res;
  endfunction

  function automatic void apply_load(input request_t r);
    case (r.func)
      FUNC_SHAPE:  shape_mem[r.row_index*NQ + r.quad_index] = r.load_value;
      FUNC_WEIGHT: weight_mem[r.quad_index] = r.load_value;
      FUNC_D:      d_mem[(r.quad_index*NE + r.equ_index)*NC + r.comp_index] = r.load_value;
      FUNC_Y:      y_mem[r.quad_index*NE + r.equ_index] = r.load_value;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
  endtask

  // drive one request; leaves the caller at a falling edge
  task automatic send_request(input request_t r, input logic typed, input sum_t want);
    int gap;
    req_if.valid      <= 1'b1;
    req_if.func       <= r.func;
    req_if.row_index  <= r.row_index;
    req_if.col_node   <= r.col_node;
    req_if.quad_index <= r.quad_index;
    req_if.equ_index  <= r.equ_index;
    req_if.comp_index <= r.comp_index;
    req_if.load_value <= r.load_value;
    do @(posedge clk); while (!req_if.ready);
    if (r.func == FUNC_MAT || r.func == FUNC_RHS) begin
      n_queries++;
      pending_sums.push_back(typed ? want : quadrature_sum(r));
    end else begin
      if (r.func != FUNC_SPARE_A && r.func != FUNC_SPARE_B) n_loads++;
      apply_load(r);
    end
    @(negedge clk);
    if (!send_eager && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drop_requests();
    req_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_QUAD: n_quad   = val;
      REG_SIDE: n_side   = val;
      REG_EQU:  n_equ    = val[2:0];
      REG_COMP: n_comp   = val[2:0];
      REG_DPP:  d_varies = val[0];
      REG_YPP:  y_varies = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_sums();
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    if (sel < 85) return $urandom;
    case ($urandom_range(0, 4))
      0: return SAT_POS;
      1: return SAT_NEG;
      2: return '0;
      3: return '1;
      default: return ONE_Q16;
    endcase
  endfunction

  function automatic logic [2:0] pick_index(input int count, input int width_max);
    if (count >= 1 && count <= width_max + 1 && $urandom_range(0, 9) < 8)
      return 3'($urandom_range(0, count - 1));
    return 3'($urandom_range(0, width_max));
  endfunction

  function automatic request_t random_request();
    request_t r;
    int sel;
    r.func       = 3'($urandom_range(0, 7));
    r.row_index  = 3'($urandom_range(0, 7));
    r.col_node   = 3'($urandom_range(0, 7));
    r.quad_index = 3'($urandom_range(0, 7));
    r.equ_index  = 2'($urandom_range(0, 3));
    r.comp_index = 2'($urandom_range(0, 3));
    r.load_value = pick_value();
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      r.func       = (sel < 45) ? FUNC_MAT : FUNC_RHS;
      r.row_index  = pick_index(int'(n_side), 7);
      r.col_node   = pick_index(int'(n_side), 7);
      r.equ_index  = 2'(pick_index(int'(n_equ), 3));
      r.comp_index = 2'(pick_index(int'(n_comp), 3));
    end else if (sel < 95) begin
      r.func = 3'($urandom_range(FUNC_SHAPE, FUNC_Y));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    sum_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("unexpected sum", rsp_if.sum_value, '0);
      end else begin
        want = pending_sums.pop_front();
        n_sums++;
        if (rsp_if.saturated) n_clipped++;
        if (rsp_if.sum_value !== want.sum_value)
          report_mismatch("sum_value", rsp_if.sum_value, want.sum_value);
        if (rsp_if.saturated !== want.saturated)
          report_mismatch("saturated", 32'(rsp_if.saturated), 32'(want.saturated));
      end
    end
  end

  initial begin
    int len;
    rsp_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end else if (!rsp_eager && $urandom_range(0, 3) == 0) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        rsp_if.ready <= 1'b0;
        repeat (len) @(negedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog expired with %0d sums outstanding", pending_sums.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    row_t     rows [$];
    request_t r;
    sum_t     z;
    logic [3:0] qv, sv, dv, yv;
    logic [2:0] ev, cv;
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.func = FUNC_SHAPE;
    req_if.row_index = '0;
    req_if.col_node = '0;
    req_if.quad_index = '0;
    req_if.equ_index = '0;
    req_if.comp_index = '0;
    req_if.load_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_QUAD;
    cfg_if.data = '0;
    errors = 0;
    n_loads = 0;
    n_queries = 0;
    n_sums = 0;
    n_clipped = 0;
    hold_rsp = 1'b0;
    send_eager = 1'b0;
    rsp_eager = 1'b0;
    idle_cycles = 0;
    n_quad = 4'd1;
    n_side = 4'd1;
    n_equ = 3'd1;
    n_comp = 3'd1;
    d_varies = 1'b0;
    y_varies = 1'b0;
    z = '0;

    rows = '{
      '{'{FUNC_SHAPE,  3'd0, 3'd0, 3'd0, 2'd0, 2'd0, ONE_Q16}, 1'b0, z},
      '{'{FUNC_WEIGHT, 3'd0, 3'd0, 3'd0, 2'd0, 2'd0, ONE_Q16}, 1'b0, z},
      '{'{FUNC_D,      3'd0, 3'd0, 3'd0, 2'd0, 2'd0, ONE_Q16}, 1'b0, z},
      '{'{FUNC_Y,      3'd0, 3'd0, 3'd0, 2'd0, 2'd0, ONE_Q16}, 1'b0, z},
      '{'{FUNC_MAT,    3'd0, 3'd0, 3'd0, 2'd0, 2'd0, '0}, 1'b1, '{ONE_Q16, 1'b0}},
      '{'{FUNC_RHS,    3'd0, 3'd0, 3'd0, 2'd0, 2'd0, '0}, 1'b1, '{ONE_Q16, 1'b0}},
      '{'{FUNC_MAT,    3'd1, 3'd0, 3'd0, 2'd0, 2'd0, '0}, 1'b1, '{32'd0, 1'b0}},
      '{'{FUNC_MAT,    3'd0, 3'd7, 3'd0, 2'd0, 2'd0, '0}, 1'b1, '{32'd0, 1'b0}},
      '{'{FUNC_MAT,    3'd0, 3'd0, 3'd0, 2'd0, 2'd3, '0}, 1'b1, '{32'd0, 1'b0}},
      '{'{FUNC_RHS,    3'd0, 3'd0, 3'd0, 2'd3, 2'd0, '0}, 1'b1, '{32'd0, 1'b0}},
      '{'{FUNC_SPARE_A, 3'd7, 3'd7, 3'd7, 2'd3, 2'd3, '1}, 1'b0, z},
      '{'{FUNC_SPARE_B, 3'd0, 3'd0, 3'd0, 2'd0, 2'd0, '0}, 1'b0, z},
      '{'{FUNC_D,      3'd0, 3'd0, 3'd0, 2'd0, 2'd0, SAT_POS}, 1'b0, z},
      '{'{FUNC_MAT,    3'd0, 3'd0, 3'd0, 2'd0, 2'd0, '0}, 1'b1, '{SAT_POS, 1'b0}},
      '{'{FUNC_SHAPE,  3'd0, 3'd0, 3'd0, 2'd0, 2'd0, SAT_NEG}, 1'b0, z},
      '{'{FUNC_MAT,    3'd0, 3'd0, 3'd0, 2'd0, 2'd0, '0}, 1'b1, '{SAT_POS, 1'b1}},
      '{'{FUNC_Y,      3'd0, 3'd0, 3'd0, 2'd0, 2'd0, SAT_POS}, 1'b0, z},
      '{'{FUNC_RHS,    3'd0, 3'd0, 3'd0, 2'd0, 2'd0, '0}, 1'b1, '{SAT_NEG, 1'b1}},
      '{'{FUNC_WEIGHT, 3'd0, 3'd0, 3'd0, 2'd0, 2'd0, 32'hFFFF_8000}, 1'b0, z},
      '{'{FUNC_SHAPE,  3'd0, 3'd0, 3'd0, 2'd0, 2'd0, ONE_Q16}, 1'b0, z},
      '{'{FUNC_RHS,    3'd0, 3'd0, 3'd0, 2'd0, 2'd0, '0}, 1'b0, z},
      '{'{FUNC_SHAPE,  3'd7, 3'd0, 3'd7, 2'd0, 2'd0, SAT_NEG}, 1'b0, z},
      '{'{FUNC_D,      3'd0, 3'd0, 3'd7, 2'd3, 2'd3, SAT_POS}, 1'b0, z},
      '{'{FUNC_Y,      3'd0, 3'd0, 3'd7, 2'd3, 2'd0, '1}, 1'b0, z},
      '{'{FUNC_MAT,    3'd0, 3'd0, 3'd0, 2'd0, 2'd0, '0}, 1'b0, z}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].sum);
    drop_requests();

    // fill every store entry so no later query reads stale data
    for (int s = 0; s < NS; s++)
      for (int q = 0; q < NQ; q++)
        send_request('{FUNC_SHAPE, s[2:0], 3'(q), q[2:0], 2'd0, 2'd0, pick_value()}, 1'b0, z);
    for (int q = 0; q < NQ; q++) begin
      send_request('{FUNC_WEIGHT, 3'd0, 3'd0, q[2:0], 2'd0, 2'd0, pick_value()}, 1'b0, z);
      for (int k = 0; k < NE; k++) begin
        send_request('{FUNC_Y, 3'd0, 3'd0, q[2:0], k[1:0], 2'd0, pick_value()}, 1'b0, z);
        for (int m = 0; m < NC; m++)
          send_request('{FUNC_D, 3'd0, 3'd0, q[2:0], k[1:0], m[1:0], pick_value()}, 1'b0, z);
      end
    end
    drop_requests();

    for (int p = 0; p < PHASES; p++) begin
      drain_sums();
      case (p)
        0: begin qv = 4'd8; sv = 4'd8; ev = 3'd4; cv = 3'd4; dv = 4'd1; yv = 4'd1; end
        1: begin qv = 4'd1; sv = 4'd1; ev = 3'd1; cv = 3'd1; dv = 4'd0; yv = 4'd0; end
        2: begin qv = 4'd8; sv = 4'd8; ev = 3'd4; cv = 3'd4; dv = 4'd0; yv = 4'd1; end
        3: begin qv = 4'd15; sv = 4'd15; ev = 3'd7; cv = 3'd7; dv = 4'd1; yv = 4'd0; end
        4: begin qv = 4'd0; sv = 4'd0; ev = 3'd0; cv = 3'd0; dv = 4'd1; yv = 4'd1; end
        default: begin
          qv = 4'($urandom_range(1, 8));
          sv = 4'($urandom_range(1, 8));
          ev = 3'($urandom_range(1, 4));
          cv = 3'($urandom_range(1, 4));
          dv = 4'($urandom_range(0, 1));
          yv = 4'($urandom_range(0, 1));
        end
      endcase
      write_reg(REG_QUAD, qv);
      write_reg(REG_SIDE, sv);
      write_reg(REG_EQU, {1'b0, ev});
      write_reg(REG_COMP, {1'b0, cv});
      write_reg(REG_DPP, dv);
      write_reg(REG_YPP, yv);
      send_eager = (p % 3 == 1);
      rsp_eager = (p % 4 == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 10) hold_rsp = 1'b1;
        r = random_request();
        if (p == 2 && i >= 10 && i < 40) r.func = FUNC_MAT;
        send_request(r, 1'b0, z);
      end
      drop_requests();
    end

    drain_sums();
    $display("Covered %0d loads and %0d queries over %0d register settings",
             n_loads, n_queries, PHASES + 1);
    $display("Checked %0d sums, %0d of them clipped", n_sums, n_clipped);
    if (errors == 0 && pending_sums.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
